### rtl/dslp_pkg.sv
package dslp_pkg;

  localparam int MAX_NODES   = 64;
  localparam int MAX_EDGES   = 256;
  localparam int NODE_W      = 6;
  localparam int NCNT_W      = 7;
  localparam int EDGE_W      = 8;
  localparam int ETOT_W      = 9;
  localparam int DEG_W       = 9;
  localparam int WEIGHT_BITS = 16;
  localparam int DIST_BITS   = 24;
  localparam int COUNT_W     = 64;

  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_RUN   = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic signed [DIST_BITS-1:0] DIST_MAX = {1'b0, {(DIST_BITS-1){1'b1}}};
  localparam logic signed [DIST_BITS-1:0] DIST_MIN = {1'b1, {(DIST_BITS-1){1'b0}}};

  typedef enum logic [1:0] {
    K_ADD,
    K_RANGE,
    K_RUN,
    K_CLEAR
  } kind_e;

  typedef enum logic [4:0] {
    B_IDLE,
    B_RESP,
    B_INIT,
    B_DEG_RD,
    B_DEG_ED,
    B_DEG_WR,
    B_SEED_RD,
    B_SEED_CK,
    B_KAHN_TOPO,
    B_KAHN_U,
    B_KAHN_EDGE,
    B_KAHN_ED,
    B_KAHN_WR,
    B_RLX_TOPO,
    B_RLX_UA,
    B_RLX_UB,
    B_RLX_EDGE,
    B_RLX_ED,
    B_RLX_WR,
    B_EMIT_RD,
    B_EMIT_OUT
  } bstate_e;

  typedef struct packed {
    logic [1:0]                    cmd;
    logic [NODE_W-1:0]             from_node;
    logic [NODE_W-1:0]             to_node;
    logic signed [WEIGHT_BITS-1:0] weight;
    logic [NODE_W-1:0]             source_node;
  } in_item_t;

  typedef struct packed {
    logic [NODE_W-1:0]           node_index;
    logic                        reachable;
    logic signed [DIST_BITS-1:0] short_dist;
    logic                        has_parent;
    logic [NODE_W-1:0]           parent_node;
    logic [COUNT_W-1:0]          short_path_count;
    logic signed [DIST_BITS-1:0] long_dist;
    logic [COUNT_W-1:0]          all_path_count;
    logic [1:0]                  status;
    logic                        last;
  } out_item_t;

  typedef struct packed {
    kind_e                         kind;
    logic [NODE_W-1:0]             from_node;
    logic [NODE_W-1:0]             to_node;
    logic signed [WEIGHT_BITS-1:0] weight;
    logic [NODE_W-1:0]             source_node;
  } q_item_t;

  typedef struct packed {
    logic    valid;
    q_item_t item;
  } q_head_t;

  typedef struct packed {
    logic [NODE_W-1:0]             tail;
    logic [NODE_W-1:0]             head;
    logic signed [WEIGHT_BITS-1:0] weight;
  } edge_t;

  typedef struct packed {
    logic                        reached;
    logic                        has_pred;
    logic [NODE_W-1:0]           pred;
    logic signed [DIST_BITS-1:0] sd;
    logic signed [DIST_BITS-1:0] ld;
    logic [COUNT_W-1:0]          sc;
    logic [COUNT_W-1:0]          pc;
  } node_rec_t;

endpackage

### rtl/dslp_front.sv
module dslp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [6:0]          n_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  dslp_pkg::in_item_t  in_data_i,
  output dslp_pkg::q_head_t   q_head_o,
  input  logic                q_pop_i
);
  import dslp_pkg::*;

  q_item_t    slot_q [2];
  logic       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       accept, push, pop;
  q_item_t    cls;

  assign in_stall_o = (count_q == 2'd2);
  assign accept     = in_valid_i && !in_stall_o;
  assign push       = accept && (in_data_i.cmd != CMD_NOP);
  assign pop        = q_pop_i && (count_q != 2'd0);

  always_comb begin
    cls.from_node   = in_data_i.from_node;
    cls.to_node     = in_data_i.to_node;
    cls.weight      = in_data_i.weight;
    cls.source_node = in_data_i.source_node;
    unique case (in_data_i.cmd)
      CMD_ADD: begin
        cls.kind = ({1'b0, in_data_i.from_node} < n_i && {1'b0, in_data_i.to_node} < n_i)
                   ? K_ADD : K_RANGE;
      end
      CMD_RUN: begin
        cls.kind = ({1'b0, in_data_i.source_node} < n_i) ? K_RUN : K_RANGE;
      end
      default: cls.kind = K_CLEAR;
    endcase
  end

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cls;
    end
  end

  assign q_head_o.valid = (count_q != 2'd0);
  assign q_head_o.item  = slot_q[rd_ptr_q];

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3) else $error("queue count overflow");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == 2'd2 |-> !push) else $error("push into full queue");
  a_pop_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd1 && pop && !push) |=> count_q == 2'd0)
    else $error("queue count slip");

endmodule

### rtl/dslp_back.sv
module dslp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [6:0]          n_i,
  input  dslp_pkg::q_head_t   q_head_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dslp_pkg::out_item_t out_data_o
);
  import dslp_pkg::*;

  edge_t             edge_mem [MAX_EDGES];
  logic [DEG_W-1:0]  deg_mem  [MAX_NODES];
  logic [NODE_W-1:0] topo_mem [MAX_NODES];
  node_rec_t         rec_mem  [MAX_NODES];

  bstate_e           state_q, state_d;
  q_item_t           cur_q, cur_d;
  logic [ETOT_W-1:0] total_q, total_d, idx_q, idx_d;
  logic [NCNT_W-1:0] node_q, node_d, head_q, head_d, tail_q, tail_d;
  logic [NODE_W-1:0] u_q, u_d;
  logic [1:0]        st_q, st_d;
  node_rec_t         urec_q, urec_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;

  edge_t             er_q;
  logic [DEG_W-1:0]  deg_rd_q;
  logic [NODE_W-1:0] topo_rd_q;
  node_rec_t         rec_rd_q;

  logic              edge_we, edge_re, deg_we, deg_re, topo_we, topo_re, rec_we, rec_re;
  logic [EDGE_W-1:0] edge_waddr;
  edge_t             edge_wdata;
  logic [NODE_W-1:0] deg_waddr, deg_raddr, topo_waddr, topo_raddr, rec_waddr, rec_raddr;
  logic [DEG_W-1:0]  deg_wdata;
  logic [NODE_W-1:0] topo_wdata;
  node_rec_t         rec_wdata;

  logic edge_end, live, match, last_node, out_free, tbl_full;
  logic signed [DIST_BITS:0]   w_ext, sd_sum, ld_sum;
  logic signed [DIST_BITS-1:0] sd_new, ld_new;
  node_rec_t vnew;

  assign edge_end  = (idx_q == total_q);
  assign live      = ({1'b0, er_q.tail} < n_i) && ({1'b0, er_q.head} < n_i);
  assign match     = live && (er_q.tail == u_q);
  assign last_node = (node_q == (n_i - 7'd1));
  assign out_free  = !out_valid_q || !out_stall_i;
  assign tbl_full  = (total_q == ETOT_W'(MAX_EDGES));

  // relaxation of edge u->v; u record in urec_q, v record in rec_rd_q
  always_comb begin
    w_ext  = {{(DIST_BITS+1-WEIGHT_BITS){er_q.weight[WEIGHT_BITS-1]}}, er_q.weight};
    sd_sum = {urec_q.sd[DIST_BITS-1], urec_q.sd} + w_ext;
    ld_sum = {urec_q.ld[DIST_BITS-1], urec_q.ld} + w_ext;
    if (sd_sum[DIST_BITS] != sd_sum[DIST_BITS-1]) begin
      sd_new = sd_sum[DIST_BITS] ? DIST_MIN : DIST_MAX;
    end else begin
      sd_new = sd_sum[DIST_BITS-1:0];
    end
    if (ld_sum[DIST_BITS] != ld_sum[DIST_BITS-1]) begin
      ld_new = ld_sum[DIST_BITS] ? DIST_MIN : DIST_MAX;
    end else begin
      ld_new = ld_sum[DIST_BITS-1:0];
    end
    vnew    = rec_rd_q;
    vnew.pc = rec_rd_q.pc + urec_q.pc;
    if (urec_q.reached) begin
      if (!rec_rd_q.reached) begin
        vnew.reached  = 1'b1;
        vnew.sd       = sd_new;
        vnew.ld       = ld_new;
        vnew.pred     = u_q;
        vnew.has_pred = 1'b1;
        vnew.sc       = urec_q.sc;
      end else begin
        if (sd_new < rec_rd_q.sd) begin
          vnew.sd       = sd_new;
          vnew.pred     = u_q;
          vnew.has_pred = 1'b1;
          vnew.sc       = urec_q.sc;
        end else if (sd_new == rec_rd_q.sd) begin
          vnew.sc = rec_rd_q.sc + urec_q.sc;
        end
        if (ld_new > rec_rd_q.ld) begin
          vnew.ld = ld_new;
        end
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: begin
        if (q_head_i.valid) begin
          state_d = (q_head_i.item.kind == K_RUN) ? B_INIT : B_RESP;
        end
      end
      B_RESP:      if (out_free) state_d = B_IDLE;
      B_INIT:      if (last_node) state_d = B_DEG_RD;
      B_DEG_RD:    state_d = edge_end ? B_SEED_RD : B_DEG_ED;
      B_DEG_ED:    state_d = live ? B_DEG_WR : B_DEG_RD;
      B_DEG_WR:    state_d = B_DEG_RD;
      B_SEED_RD:   state_d = B_SEED_CK;
      B_SEED_CK:   state_d = last_node ? B_KAHN_TOPO : B_SEED_RD;
      B_KAHN_TOPO: state_d = (head_q == tail_q) ? B_RLX_TOPO : B_KAHN_U;
      B_KAHN_U:    state_d = B_KAHN_EDGE;
      B_KAHN_EDGE: state_d = edge_end ? B_KAHN_TOPO : B_KAHN_ED;
      B_KAHN_ED:   state_d = match ? B_KAHN_WR : B_KAHN_EDGE;
      B_KAHN_WR:   state_d = B_KAHN_EDGE;
      B_RLX_TOPO:  state_d = (head_q == tail_q) ? B_EMIT_RD : B_RLX_UA;
      B_RLX_UA:    state_d = B_RLX_UB;
      B_RLX_UB:    state_d = B_RLX_EDGE;
      B_RLX_EDGE:  state_d = edge_end ? B_RLX_TOPO : B_RLX_ED;
      B_RLX_ED:    state_d = match ? B_RLX_WR : B_RLX_EDGE;
      B_RLX_WR:    state_d = B_RLX_EDGE;
      B_EMIT_RD:   state_d = B_EMIT_OUT;
      B_EMIT_OUT: begin
        if (out_free) state_d = last_node ? B_IDLE : B_EMIT_RD;
      end
      default:     state_d = B_IDLE;
    endcase
  end

  // datapath and strobes
  always_comb begin
    cur_d      = cur_q;
    total_d    = total_q;
    idx_d      = idx_q;
    node_d     = node_q;
    head_d     = head_q;
    tail_d     = tail_q;
    u_d        = u_q;
    st_d       = st_q;
    urec_d     = urec_q;
    out_d      = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    q_pop_o    = 1'b0;
    edge_we    = 1'b0;
    edge_re    = 1'b0;
    edge_waddr = total_q[EDGE_W-1:0];
    edge_wdata.tail   = cur_q.from_node;
    edge_wdata.head   = cur_q.to_node;
    edge_wdata.weight = cur_q.weight;
    deg_we     = 1'b0;
    deg_re     = 1'b0;
    deg_waddr  = er_q.head;
    deg_raddr  = er_q.head;
    deg_wdata  = deg_rd_q + DEG_W'(1);
    topo_we    = 1'b0;
    topo_re    = 1'b0;
    topo_waddr = tail_q[NODE_W-1:0];
    topo_raddr = head_q[NODE_W-1:0];
    topo_wdata = er_q.head;
    rec_we     = 1'b0;
    rec_re     = 1'b0;
    rec_waddr  = er_q.head;
    rec_raddr  = er_q.head;
    rec_wdata  = vnew;

    unique case (state_q)
      B_IDLE: begin
        if (q_head_i.valid) begin
          q_pop_o = 1'b1;
          cur_d   = q_head_i.item;
          node_d  = '0;
          unique case (q_head_i.item.kind)
            K_ADD: begin
              st_d = ST_OK;
              if (total_q == ETOT_W'(MAX_EDGES)) begin
                st_d = ST_FULL;
              end
            end
            K_RANGE: st_d = ST_RANGE;
            K_CLEAR: begin
              st_d    = ST_OK;
              total_d = '0;
            end
            K_RUN:   st_d = ST_OK;
            default: st_d = ST_RANGE;
          endcase
        end
      end
      B_RESP: begin
        if (cur_q.kind == K_ADD && st_q == ST_OK && !tbl_full && out_free) begin
          edge_we = 1'b1;
          total_d = total_q + ETOT_W'(1);
        end
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '0;
          out_d.status = st_q;
          out_d.last   = 1'b1;
        end
      end
      B_INIT: begin
        rec_we    = 1'b1;
        rec_waddr = node_q[NODE_W-1:0];
        rec_wdata = '0;
        if (node_q[NODE_W-1:0] == cur_q.source_node) begin
          rec_wdata.reached = 1'b1;
          rec_wdata.sc      = COUNT_W'(1);
          rec_wdata.pc      = COUNT_W'(1);
        end
        deg_we    = 1'b1;
        deg_waddr = node_q[NODE_W-1:0];
        deg_wdata = '0;
        node_d    = node_q + NCNT_W'(1);
        if (last_node) begin
          idx_d = '0;
        end
      end
      B_DEG_RD: begin
        if (edge_end) begin
          node_d = '0;
          tail_d = '0;
        end else begin
          edge_re = 1'b1;
        end
      end
      B_DEG_ED: begin
        if (live) begin
          deg_re = 1'b1;
        end else begin
          idx_d = idx_q + ETOT_W'(1);
        end
      end
      B_DEG_WR: begin
        deg_we = 1'b1;
        idx_d  = idx_q + ETOT_W'(1);
      end
      B_SEED_RD: begin
        deg_re    = 1'b1;
        deg_raddr = node_q[NODE_W-1:0];
      end
      B_SEED_CK: begin
        if (deg_rd_q == '0) begin
          topo_we    = 1'b1;
          topo_wdata = node_q[NODE_W-1:0];
          tail_d     = tail_q + NCNT_W'(1);
        end
        node_d = node_q + NCNT_W'(1);
        if (last_node) begin
          head_d = '0;
        end
      end
      B_KAHN_TOPO: begin
        if (head_q == tail_q) begin
          head_d = '0;
        end else begin
          topo_re = 1'b1;
          head_d  = head_q + NCNT_W'(1);
        end
      end
      B_KAHN_U: begin
        u_d   = topo_rd_q;
        idx_d = '0;
      end
      B_KAHN_EDGE: begin
        if (!edge_end) edge_re = 1'b1;
      end
      B_KAHN_ED: begin
        if (match) begin
          deg_re = 1'b1;
        end else begin
          idx_d = idx_q + ETOT_W'(1);
        end
      end
      B_KAHN_WR: begin
        deg_we    = 1'b1;
        deg_wdata = deg_rd_q - DEG_W'(1);
        if (deg_rd_q == DEG_W'(1) && tail_q < NCNT_W'(MAX_NODES)) begin
          topo_we = 1'b1;
          tail_d  = tail_q + NCNT_W'(1);
        end
        idx_d = idx_q + ETOT_W'(1);
      end
      B_RLX_TOPO: begin
        if (head_q == tail_q) begin
          node_d = '0;
        end else begin
          topo_re = 1'b1;
          head_d  = head_q + NCNT_W'(1);
        end
      end
      B_RLX_UA: begin
        rec_re    = 1'b1;
        rec_raddr = topo_rd_q;
        u_d       = topo_rd_q;
      end
      B_RLX_UB: begin
        urec_d = rec_rd_q;
        idx_d  = '0;
      end
      B_RLX_EDGE: begin
        if (!edge_end) edge_re = 1'b1;
      end
      B_RLX_ED: begin
        if (match) begin
          rec_re = 1'b1;
        end else begin
          idx_d = idx_q + ETOT_W'(1);
        end
      end
      B_RLX_WR: begin
        rec_we = 1'b1;
        idx_d  = idx_q + ETOT_W'(1);
      end
      B_EMIT_RD: begin
        rec_re    = 1'b1;
        rec_raddr = node_q[NODE_W-1:0];
      end
      B_EMIT_OUT: begin
        if (out_free) begin
          out_valid_d          = 1'b1;
          out_d.node_index     = node_q[NODE_W-1:0];
          out_d.reachable      = rec_rd_q.reached;
          out_d.short_dist     = rec_rd_q.reached ? rec_rd_q.sd : '0;
          out_d.has_parent     = rec_rd_q.reached && rec_rd_q.has_pred;
          out_d.parent_node    = (rec_rd_q.reached && rec_rd_q.has_pred) ? rec_rd_q.pred : '0;
          out_d.short_path_count = rec_rd_q.reached ? rec_rd_q.sc : '0;
          out_d.long_dist      = rec_rd_q.reached ? rec_rd_q.ld : '0;
          out_d.all_path_count = rec_rd_q.reached ? rec_rd_q.pc : '0;
          out_d.status         = ST_OK;
          out_d.last           = last_node;
          node_d               = node_q + NCNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    idx_q  <= idx_d;
    node_q <= node_d;
    head_q <= head_d;
    tail_q <= tail_d;
    u_q    <= u_d;
    st_q   <= st_d;
    urec_q <= urec_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (edge_we) edge_mem[edge_waddr] <= edge_wdata;
    if (edge_re) er_q <= edge_mem[idx_q[EDGE_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (deg_we) deg_mem[deg_waddr] <= deg_wdata;
    if (deg_re) deg_rd_q <= deg_mem[deg_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (topo_we) topo_mem[topo_waddr] <= topo_wdata;
    if (topo_re) topo_rd_q <= topo_mem[topo_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (rec_we) rec_mem[rec_waddr] <= rec_wdata;
    if (rec_re) rec_rd_q <= rec_mem[rec_raddr];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= ETOT_W'(MAX_EDGES)) else $error("edge count past table size");
  a_order_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_KAHN_EDGE || state_q == B_RLX_EDGE) |-> head_q <= tail_q)
    else $error("order head past tail");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> state_q == B_IDLE) else $error("pop outside idle");
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_EMIT_OUT && out_free && last_node) |=> state_q == B_IDLE)
    else $error("run did not end after last beat");

endmodule

### rtl/dag_shortest_longest_path.sv
// DAG shortest/longest path engine. Add-edge and clear items are answered with a status beat;
// a run from a valid source passes through an init pass, an in-degree pass, a seed pass and
// the ordering and relaxation passes, then emits one result beat per node. Its run time is
// set by the single read port of the edge table, which is scanned in full for every node
// taken from the order. A two-entry queue sits between the intake and the engine, and
// results leave through an output register.
module dag_shortest_longest_path (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [6:0]          cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  dslp_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dslp_pkg::out_item_t out_data_o
);
  import dslp_pkg::*;

  logic [6:0] node_count_q;
  logic [6:0] n_eff;
  q_head_t    q_head;
  logic       q_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= 7'(MAX_NODES);
    end else if (cfg_we_i) begin
      node_count_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (node_count_q == 7'd0) begin
      n_eff = 7'd1;
    end else if (node_count_q > 7'(MAX_NODES)) begin
      n_eff = 7'(MAX_NODES);
    end else begin
      n_eff = node_count_q;
    end
  end

  dslp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .n_i        (n_eff),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_head_o   (q_head),
    .q_pop_i    (q_pop)
  );

  dslp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .n_i         (n_eff),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

### tb/sv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dslp_pkg::*;

  localparam int CYCLE_LIMIT = 100000000;

  typedef struct packed {
    logic             typed;
    out_item_t        res;
  } fixed_res_t;

  typedef struct packed {
    in_item_t         item;
    logic             typed;
    logic [1:0]       st;
  } stim_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      cfg_we_i = 1'b0;
  logic [6:0] cfg_wdata_i = '0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;

  dag_shortest_longest_path u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #2 clk_i = ~clk_i;

  // shadow of the graph and the node count register
  logic [NODE_W-1:0]             g_tail [MAX_EDGES];
  logic [NODE_W-1:0]             g_head [MAX_EDGES];
  logic signed [WEIGHT_BITS-1:0] g_wt   [MAX_EDGES];
  int                            g_edges = 0;
  logic [NCNT_W-1:0]             g_ncfg = 7'd64;

  out_item_t  path_q [$];
  fixed_res_t fixed_q [$];
  int         errors = 0;
  int         cycles = 0;
  bit         quiet = 0;
  bit         hold_req = 0;

  function automatic int nodes_live();
    if (g_ncfg == 0) return 1;
    if (g_ncfg > MAX_NODES) return MAX_NODES;
    return int'(g_ncfg);
  endfunction

  function automatic out_item_t status_beat(logic [1:0] st);
    out_item_t r;
    r = '0;
    r.status = st;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic void expect_beat(out_item_t r);
    path_q = {path_q, r};
  endfunction

  function automatic longint sat_dist(longint a);
    if (a > longint'(DIST_MAX)) return longint'(DIST_MAX);
    if (a < longint'(DIST_MIN)) return longint'(DIST_MIN);
    return a;
  endfunction

  function automatic bit edge_on(int e, int n);
    return int'(g_tail[e]) < n && int'(g_head[e]) < n;
  endfunction

  function automatic void solve_paths(int src, int n);
    int             deg [MAX_NODES];
    int             ord [MAX_NODES];
    bit             rch [MAX_NODES];
    bit             hp  [MAX_NODES];
    int             par [MAX_NODES];
    longint         sd  [MAX_NODES];
    longint         ld  [MAX_NODES];
    logic [63:0]    sc  [MAX_NODES];
    logic [63:0]    pc  [MAX_NODES];
    int             hd, tl, u, v;
    longint         s, l;
    out_item_t      r;
    tl = 0;
    for (int i = 0; i < MAX_NODES; i++) begin
      deg[i] = 0; rch[i] = 0; hp[i] = 0; par[i] = 0;
      sd[i] = 0; ld[i] = 0; sc[i] = '0; pc[i] = '0;
    end
    for (int e = 0; e < g_edges; e++)
      if (edge_on(e, n)) deg[g_head[e]]++;
    for (int i = 0; i < n; i++)
      if (deg[i] == 0) begin ord[tl] = i; tl++; end
    hd = 0;
    while (hd < tl) begin
      u = ord[hd];
      hd++;
      for (int e = 0; e < g_edges; e++) begin
        if (!edge_on(e, n) || int'(g_tail[e]) != u) continue;
        deg[g_head[e]]--;
        if (deg[g_head[e]] == 0 && tl < MAX_NODES) begin
          ord[tl] = int'(g_head[e]);
          tl++;
        end
      end
    end
    rch[src] = 1; sc[src] = 64'd1; pc[src] = 64'd1;
    for (int k = 0; k < tl; k++) begin
      u = ord[k];
      for (int e = 0; e < g_edges; e++) begin
        if (!edge_on(e, n) || int'(g_tail[e]) != u) continue;
        v = int'(g_head[e]);
        pc[v] = pc[v] + pc[u];
        if (!rch[u]) continue;
        s = sat_dist(sd[u] + longint'(g_wt[e]));
        l = sat_dist(ld[u] + longint'(g_wt[e]));
        if (!rch[v]) begin
          rch[v] = 1; sd[v] = s; ld[v] = l; par[v] = u; hp[v] = 1; sc[v] = sc[u];
        end else begin
          if (s < sd[v]) begin
            sd[v] = s; par[v] = u; hp[v] = 1; sc[v] = sc[u];
          end else if (s == sd[v]) begin
            sc[v] = sc[v] + sc[u];
          end
          if (l > ld[v]) ld[v] = l;
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      r = '0;
      r.node_index = i[NODE_W-1:0];
      if (rch[i]) begin
        r.reachable = 1'b1;
        r.short_dist = sd[i][DIST_BITS-1:0];
        r.has_parent = hp[i];
        r.parent_node = hp[i] ? par[i][NODE_W-1:0] : '0;
        r.short_path_count = sc[i];
        r.long_dist = ld[i][DIST_BITS-1:0];
        r.all_path_count = pc[i];
      end
      r.last = (i == n - 1);
      expect_beat(r);
    end
  endfunction

  function automatic void predict_beat(in_item_t it);
    int n;
    n = nodes_live();
    case (it.cmd)
      CMD_ADD: begin
        if (int'(it.from_node) >= n || int'(it.to_node) >= n) begin
          expect_beat(status_beat(ST_RANGE));
        end else if (g_edges >= MAX_EDGES) begin
          expect_beat(status_beat(ST_FULL));
        end else begin
          g_tail[g_edges] = it.from_node;
          g_head[g_edges] = it.to_node;
          g_wt[g_edges] = it.weight;
          g_edges++;
          expect_beat(status_beat(ST_OK));
        end
      end
      CMD_RUN: begin
        if (int'(it.source_node) >= n) expect_beat(status_beat(ST_RANGE));
        else solve_paths(int'(it.source_node), n);
      end
      CMD_CLEAR: begin
        g_edges = 0;
        expect_beat(status_beat(ST_OK));
      end
      default: ;
    endcase
  endfunction

  out_item_t  want;
  fixed_res_t fx;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
    if (rst_ni && in_valid_i && !in_stall_o) begin
      fx = fixed_q.pop_front();
      predict_beat(in_data_i);
      if (fx.typed) begin
        path_q[path_q.size() - 1] = fx.res;
      end
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (path_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %p", out_data_o);
      end else begin
        want = path_q.pop_front();
        if (out_data_o.node_index !== want.node_index ||
            out_data_o.reachable !== want.reachable ||
            out_data_o.short_dist !== want.short_dist ||
            out_data_o.has_parent !== want.has_parent ||
            out_data_o.parent_node !== want.parent_node ||
            out_data_o.short_path_count !== want.short_path_count ||
            out_data_o.long_dist !== want.long_dist ||
            out_data_o.all_path_count !== want.all_path_count ||
            out_data_o.status !== want.status ||
            out_data_o.last !== want.last) begin
          errors++;
          if (errors <= 10) $display("mismatch: exp %p got %p", want, out_data_o);
        end
      end
    end
  end

  // receiver: random stall bursts, one long hold on request
  initial begin
    int k;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i = 1'b1;
        repeat (400) @(negedge clk_i);
        out_stall_i = 1'b0;
        hold_req = 0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        k = $urandom_range(1, 19);
        out_stall_i = 1'b1;
        repeat (k - 1) @(negedge clk_i);
      end else begin
        out_stall_i = 1'b0;
      end
    end
  end

  task automatic send(in_item_t it, int typed, logic [1:0] st);
    int         k;
    fixed_res_t f;
    @(negedge clk_i);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      k = $urandom_range(1, 19);
      in_valid_i = 1'b0;
      repeat (k) @(negedge clk_i);
    end
    f.typed = (typed != 0);
    f.res = status_beat(st);
    fixed_q = {fixed_q, f};
    in_data_i = it;
    in_valid_i = 1'b1;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (path_q.size() != 0 || fixed_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_nodes(logic [6:0] v);
    drain();
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    g_ncfg = v;
  endtask

  function automatic in_item_t mk(logic [1:0] c, int f, int t, int w, int s);
    in_item_t it;
    it.cmd = c;
    it.from_node = f[NODE_W-1:0];
    it.to_node = t[NODE_W-1:0];
    it.weight = w[WEIGHT_BITS-1:0];
    it.source_node = s[NODE_W-1:0];
    return it;
  endfunction

  function automatic stim_row_t row(in_item_t it, int typed, logic [1:0] st);
    stim_row_t r;
    r.item = it;
    r.typed = (typed != 0);
    r.st = st;
    return r;
  endfunction

  function automatic in_item_t rand_item(int n);
    in_item_t it;
    int       r, f;
    it.cmd = 2'($urandom);
    it.from_node = NODE_W'($urandom);
    it.to_node = NODE_W'($urandom);
    it.weight = WEIGHT_BITS'($urandom);
    it.source_node = NODE_W'($urandom);
    r = $urandom_range(0, 99);
    if (r < 55) begin
      it.cmd = CMD_ADD;
      if (n > 1) begin
        f = int'($urandom_range(0, n - 2));
        it.from_node = f[NODE_W-1:0];
        it.to_node = NODE_W'($urandom_range(f + 1, n - 1));
      end else begin
        it.from_node = '0;
        it.to_node = '0;
      end
    end else if (r < 63) begin
      it.cmd = CMD_ADD;
      it.from_node = NODE_W'($urandom_range(0, n - 1));
      it.to_node = NODE_W'($urandom_range(0, n - 1));
    end else if (r < 70) begin
      it.cmd = CMD_ADD;
    end else if (r < 86) begin
      it.cmd = CMD_RUN;
      it.source_node = NODE_W'($urandom_range(0, n - 1));
    end else if (r < 91) begin
      it.cmd = CMD_RUN;
    end else if (r < 95) begin
      it.cmd = CMD_CLEAR;
    end else begin
      it.cmd = CMD_NOP;
    end
    return it;
  endfunction

  stim_row_t dir_tbl [$];
  logic [6:0] phase_n [6] = '{7'd8, 7'd0, 7'd127, 7'd5, 7'd12, 7'd8};

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    dir_tbl = {dir_tbl, row(mk(CMD_RUN, 0, 0, 0, 0), 0, ST_OK)};
    dir_tbl = {dir_tbl, row(mk(CMD_ADD, 0, 1, 32767, 0), 1, ST_OK)};
    dir_tbl = {dir_tbl, row(mk(CMD_ADD, 1, 2, 32767, 0), 1, ST_OK)};
    dir_tbl = {dir_tbl, row(mk(CMD_ADD, 0, 2, -32768, 0), 1, ST_OK)};
    dir_tbl = {dir_tbl, row(mk(CMD_ADD, 1, 2, -32768, 0), 1, ST_OK)};
    dir_tbl = {dir_tbl, row(mk(CMD_ADD, 3, 3, 5, 0), 1, ST_OK)};
    dir_tbl = {dir_tbl, row(mk(CMD_ADD, 3, 4, 7, 0), 1, ST_OK)};
    dir_tbl = {dir_tbl, row(mk(CMD_ADD, 63, 0, -1, 0), 1, ST_OK)};
    dir_tbl = {dir_tbl, row(mk(CMD_ADD, 2, 62, 0, 0), 1, ST_OK)};
    dir_tbl = {dir_tbl, row(mk(CMD_NOP, 63, 63, -1, 63), 0, ST_OK)};
    dir_tbl = {dir_tbl, row(mk(CMD_RUN, 0, 0, 0, 63), 0, ST_OK)};
    dir_tbl = {dir_tbl, row(mk(CMD_RUN, 0, 0, 0, 0), 0, ST_OK)};
    dir_tbl = {dir_tbl, row(mk(CMD_RUN, 0, 0, 0, 3), 0, ST_OK)};
    foreach (dir_tbl[i]) send(dir_tbl[i].item, dir_tbl[i].typed, dir_tbl[i].st);

    // lowered count: range errors and stale edges
    set_nodes(7'd4);
    dir_tbl.delete();
    dir_tbl = {dir_tbl, row(mk(CMD_ADD, 5, 1, 1, 0), 1, ST_RANGE)};
    dir_tbl = {dir_tbl, row(mk(CMD_ADD, 1, 63, 1, 0), 1, ST_RANGE)};
    dir_tbl = {dir_tbl, row(mk(CMD_RUN, 0, 0, 0, 9), 1, ST_RANGE)};
    dir_tbl = {dir_tbl, row(mk(CMD_RUN, 0, 0, 0, 0), 0, ST_OK)};
    dir_tbl = {dir_tbl, row(mk(CMD_CLEAR, 0, 0, 0, 0), 1, ST_OK)};
    dir_tbl = {dir_tbl, row(mk(CMD_RUN, 0, 0, 0, 1), 0, ST_OK)};
    foreach (dir_tbl[i]) send(dir_tbl[i].item, dir_tbl[i].typed, dir_tbl[i].st);

    // receiver holds off while adds keep coming, then sender waits it out
    drain();
    hold_req = 1;
    for (int i = 0; i < 12; i++) send(mk(CMD_ADD, i % 3, 3, i, 0), 0, ST_OK);
    drain();

    // fill the table: triple parallel chain, wrapping path counts, then overflow
    set_nodes(7'd64);
    send(mk(CMD_CLEAR, 0, 0, 0, 0), 1, ST_OK);
    for (int i = 0; i < 63; i++)
      for (int j = 0; j < 3; j++) send(mk(CMD_ADD, i, i + 1, j * 1000 - 1000, 0), 0, ST_OK);
    for (int i = 0; i < 67; i++) send(mk(CMD_ADD, 0, 63, i - 33, 0), 0, ST_OK);
    send(mk(CMD_ADD, 1, 2, 0, 0), 1, ST_FULL);
    send(mk(CMD_RUN, 0, 0, 0, 0), 0, ST_OK);
    send(mk(CMD_CLEAR, 0, 0, 0, 0), 1, ST_OK);

    set_nodes(7'd1);
    send(mk(CMD_ADD, 0, 0, 3, 0), 1, ST_OK);
    send(mk(CMD_RUN, 0, 0, 0, 0), 0, ST_OK);
    send(mk(CMD_RUN, 0, 0, 0, 1), 1, ST_RANGE);

    foreach (phase_n[p]) begin
      set_nodes(phase_n[p]);
      if (p == 5) quiet = 1;
      send(mk(CMD_CLEAR, 0, 0, 0, 0), 1, ST_OK);
      for (int i = 0; i < 10; i++) send(rand_item(nodes_live()), 0, ST_OK);
    end

    drain();
    repeat (200) @(posedge clk_i);
    if (errors == 0 && path_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
